// ===== rtl/core/lsp_pkg.sv =====
// Shared types, codes and helper functions for the Matroska lace splitter.
package lsp_pkg;

   localparam int LACE_W = 9;        // lace count 1..256
   localparam logic [7:0] XIPH_CONT = 8'hFF;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_XIPH  = 2'd1,
      MODE_FIXED = 2'd2,
      MODE_EBML  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ERR_OK    = 3'd0,
      ERR_XIPH  = 3'd1,
      ERR_FIXED = 3'd2,
      ERR_VINT  = 3'd3,
      ERR_NEG   = 3'd4,
      ERR_SIZE  = 3'd5
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_XIPH, ST_EBML, ST_PAY, ST_SWAL, ST_DIV, ST_DIVCHK,
      ST_VDONE, ST_VAPPLY, ST_USED, ST_FIN, ST_SKRD, ST_SKCHK
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_START, OP_XIPH, OP_EBML, OP_PAY, OP_SWAL, OP_DIV_STEP,
      OP_DIV_DONE, OP_VDONE, OP_VAPPLY, OP_USED, OP_FIN, OP_SK_CHK
   } op_type;

   typedef struct packed {
      op_type  op;
      logic    emit;
      logic    fault;
      err_type code;
   } cmd_type;

   typedef struct packed {
      logic     out_free;
      mode_type req_mode;
      mode_type mode;
      logic     first_last;
      logic     count_over;
      logic     b_zero;
      logic     b_full;
      logic     last_now;
      logic     vint_bad;
      logic     vint_done_now;
      logic     div_last;
      logic     div_rem_nz;
      logic     rem_zero;
      logic     allones;
      logic     cur_zero;
      logic     total_gt1;
      logic     neg_fault;
      logic     at_needed;
      logic     fin_fault;
      logic     lend_now;
      logic     rd_nonzero;
      logic     skip_end;
   } stat_type;

   // vint length from the leading marker bit
   function automatic logic [3:0] vint_len(input logic [7:0] b);
      logic [3:0] n;
      casez (b)
         8'b1???????: n = 4'd1;
         8'b01??????: n = 4'd2;
         8'b001?????: n = 4'd3;
         8'b0001????: n = 4'd4;
         8'b00001???: n = 4'd5;
         8'b000001??: n = 4'd6;
         8'b0000001?: n = 4'd7;
         default:     n = 4'd8;
      endcase
      return n;
   endfunction

   // all-ones value of a vint with 7 data bits per byte
   function automatic logic [55:0] vint_mask(input logic [3:0] len);
      logic [55:0] m;
      case (len)
         4'd1:    m = 56'h7F;
         4'd2:    m = 56'h3FFF;
         4'd3:    m = 56'h1F_FFFF;
         4'd4:    m = 56'hFFF_FFFF;
         4'd5:    m = 56'h7_FFFF_FFFF;
         4'd6:    m = 56'h3FF_FFFF_FFFF;
         4'd7:    m = 56'h1_FFFF_FFFF_FFFF;
         4'd8:    m = 56'hFF_FFFF_FFFF_FFFF;
         default: m = 56'h0;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/core/matroska_lace_splitter.sv =====
// Matroska block lace splitter: top level with stream ports.
//
// Usage: send the body of each block (after track, timecode and flags) one
// byte per request on req_*. Lacing mode and block length are taken from the
// block's first request only. Payload bytes come back on rsp_* tagged with
// their lace index, rsp_tlast on the last byte of each lace and a block-end
// flag on the last byte of the block. A bad lace header gives one error
// response; the rest of that block is consumed silently.
// Timing: payload bytes pass at one per cycle through the result register while
// the receiver keeps up. Each completed size adds a USED step (Xiph) or VDONE,
// an optional VAPPLY and USED steps (EBML), FIN closes the header, and a size
// lookup (SKRD, SKCHK) runs when a lace ends or payload starts, repeated for
// each empty lace that is skipped (none for fixed lacing).
// Fixed lacing runs a bit-serial divider over the block length.
// Reset returns the block to waiting for a first byte; the size RAM is not
// cleared. When rsp_tready is low and a response is held, req_tready drops
// and all internal sequencing pauses until it is taken.
module matroska_lace_splitter #(
   parameter int MAX_LACES   = 256,
   parameter int LENGTH_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // data_byte[7:0], lacing_mode[9:8], block_length[33:10]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // out_byte[7:0], lace_index[15:8]
   output logic        rsp_tlast,  // lace_end
   output logic [3:0]  rsp_tuser   // block_end[0], error_code[3:1]
);
   import lsp_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   logic [7:0] out_byte;
   logic [7:0] lace_index;
   logic       block_end;
   logic [2:0] error_code;

   lsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lsp_dp #(
      .MAX_LACES   (MAX_LACES),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_byte    (req_tdata[7:0]),
      .in_mode    (req_tdata[9:8]),
      .in_length  (req_tdata[33:10]),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .out_byte   (out_byte),
      .lace_index (lace_index),
      .lace_end   (rsp_tlast),
      .block_end  (block_end),
      .error_code (error_code)
   );

   assign rsp_tdata = {lace_index, out_byte};
   assign rsp_tuser = {error_code, block_end};

endmodule

// ===== rtl/core/lsp_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lsp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/lsp_dp.sv =====
// Datapath of the lace splitter: counters, vint/size arithmetic, divider, size RAM, result reg.
module lsp_dp #(
   parameter int MAX_LACES   = 256,
   parameter int LENGTH_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  lsp_pkg::cmd_type  cmd,
   input  logic [7:0]        in_byte,
   input  logic [1:0]        in_mode,
   input  logic [23:0]       in_length,
   output lsp_pkg::stat_type stat,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [7:0]        out_byte,
   output logic [7:0]        lace_index,
   output logic              lace_end,
   output logic              block_end,
   output logic [2:0]        error_code
);
   import lsp_pkg::*;

   localparam int LB = LENGTH_BITS;
   localparam int AW = $clog2(MAX_LACES);
   localparam int CW = $clog2(LB + 1);

   logic [LB-1:0]     rem_ff, rem_in;
   mode_type          mode_ff, mode_in;
   logic [LACE_W-1:0] total_ff, total_in;
   logic [LACE_W-1:0] cur_ff, cur_in;
   logic [63:0]       run_ff, run_in;
   logic [3:0]        vlen_ff, vlen_in;
   logic [2:0]        vleft_ff, vleft_in;
   logic [55:0]       acc_ff, acc_in;
   logic [31:0]       used_ff, used_in;
   logic              over_ff, over_in;
   logic [LB-1:0]     lbl_ff, lbl_in;
   logic [LB-1:0]     q_ff, q_in;
   logic [8:0]        r_ff, r_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [55:0]       delta_ff, delta_in;
   logic              dneg_ff, dneg_in;

   logic              valid_ff, valid_in;
   logic [7:0]        obyte_ff, obyte_in;
   logic [7:0]        oidx_ff, oidx_in;
   logic              olend_ff, olend_in;
   logic              obend_ff, obend_in;
   err_type           oerr_ff, oerr_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [LB-1:0]     ram_wdata;
   logic [LB-1:0]     rd_data;

   logic [31:0]       wide_len;
   logic [LB-1:0]     len_raw, len_eff, rem_dec, lbl_dec, fin_size;
   logic [LACE_W-1:0] total_req;
   logic              first_last, last_now, lend_now;
   logic [3:0]        vlen_new;
   logic [55:0]       acc_first, acc_cont, vmask, bias, dval;
   logic              dpos;
   logic [63:0]       run_apply, run_xiph;
   logic [32:0]       used_sum;
   logic              used_over;
   logic [9:0]        shifted;
   logic [9:0]        trial;
   logic              trial_ok;

   lsp_ram #(.WIDTH(LB), .DEPTH(MAX_LACES)) u_sizes (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (cur_ff[AW-1:0]),
      .rdata (rd_data)
   );

   always_comb begin
      wide_len   = {8'b0, in_length};
      len_raw    = wide_len[LB-1:0];
      len_eff    = (len_raw == '0) ? LB'(1) : len_raw;
      first_last = (len_eff == LB'(1));
      total_req  = {1'b0, in_byte} + LACE_W'(1);
      rem_dec    = (rem_ff == '0) ? '0 : rem_ff - LB'(1);
      last_now   = (rem_ff <= LB'(1));
      lbl_dec    = (lbl_ff == '0) ? '0 : lbl_ff - LB'(1);
      lend_now   = (lbl_dec == '0);
      vlen_new   = vint_len(in_byte);
      acc_first  = {48'b0, in_byte & (8'hFF >> vlen_new)};
      acc_cont   = {acc_ff[47:0], in_byte};
      vmask      = vint_mask(vlen_ff);
      bias       = vmask >> 1;
      dpos       = (acc_ff >= bias);
      dval       = dpos ? (acc_ff - bias) : (bias - acc_ff);
      run_apply  = dneg_ff ? (run_ff - {8'b0, delta_ff}) : (run_ff + {8'b0, delta_ff});
      run_xiph   = run_ff + {56'b0, in_byte};
      used_sum   = {1'b0, used_ff} + {1'b0, run_ff[31:0]};
      used_over  = (run_ff[63:32] != '0) || used_sum[32];
      fin_size   = rem_ff - used_ff[LB-1:0];
      shifted    = {r_ff, q_ff[LB-1]};
      trial      = shifted - {1'b0, total_ff};
      trial_ok   = (shifted >= {1'b0, total_ff});
   end

   always_comb begin
      stat.out_free      = !valid_ff || rsp_tready;
      stat.req_mode      = mode_type'(in_mode);
      stat.mode          = mode_ff;
      stat.first_last    = first_last;
      stat.count_over    = (total_req > LACE_W'(MAX_LACES));
      stat.b_zero        = (in_byte == 8'h00);
      stat.b_full        = (in_byte == XIPH_CONT);
      stat.last_now      = last_now;
      stat.vint_bad      = (vleft_ff == '0) &&
                           ((in_byte == 8'h00) ||
                            ((LB+1)'(vlen_new) > ({1'b0, rem_dec} + (LB+1)'(1))));
      stat.vint_done_now = (vleft_ff == '0) ? (vlen_new == 4'd1) : (vleft_ff == 3'd1);
      stat.div_last      = (cnt_ff == CW'(1));
      stat.div_rem_nz    = (r_ff != '0);
      stat.rem_zero      = (rem_ff == '0);
      stat.allones       = (acc_ff == vmask);
      stat.cur_zero      = (cur_ff == '0);
      stat.total_gt1     = (total_ff > LACE_W'(1));
      stat.neg_fault     = dneg_ff && ({8'b0, delta_ff} > run_ff);
      stat.at_needed     = (({1'b0, cur_ff} + (LACE_W+1)'(2)) >= {1'b0, total_ff});
      stat.fin_fault     = over_ff || ({1'b0, used_ff} > 33'(rem_ff));
      stat.lend_now      = lend_now;
      stat.rd_nonzero    = (rd_data != '0);
      stat.skip_end      = (({1'b0, cur_ff} + (LACE_W+1)'(1)) >= {1'b0, total_ff});
   end

   always_comb begin
      rem_in    = rem_ff;
      mode_in   = mode_ff;
      total_in  = total_ff;
      cur_in    = cur_ff;
      run_in    = run_ff;
      vlen_in   = vlen_ff;
      vleft_in  = vleft_ff;
      acc_in    = acc_ff;
      used_in   = used_ff;
      over_in   = over_ff;
      lbl_in    = lbl_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      cnt_in    = cnt_ff;
      delta_in  = delta_ff;
      dneg_in   = dneg_ff;
      ram_we    = 1'b0;
      ram_waddr = cur_ff[AW-1:0];
      ram_wdata = run_xiph[LB-1:0];
      case (cmd.op)
         OP_START: begin
            mode_in  = mode_type'(in_mode);
            rem_in   = len_eff - LB'(1);
            total_in = (mode_type'(in_mode) == MODE_NONE) ? LACE_W'(1) : total_req;
            cur_in   = '0;
            run_in   = '0;
            used_in  = '0;
            over_in  = 1'b0;
            vlen_in  = '0;
            vleft_in = '0;
            acc_in   = '0;
            lbl_in   = len_eff - LB'(1);
            q_in     = len_eff - LB'(1);
            r_in     = '0;
            cnt_in   = CW'(LB);
         end
         OP_XIPH: begin
            rem_in = rem_dec;
            run_in = run_xiph;
            if (in_byte != XIPH_CONT) begin
               ram_we    = 1'b1;
               ram_wdata = run_xiph[LB-1:0];
            end
         end
         OP_EBML: begin
            rem_in = rem_dec;
            if (vleft_ff == '0) begin
               acc_in   = acc_first;
               vlen_in  = vlen_new;
               vleft_in = 3'(vlen_new - 4'd1);
            end else begin
               acc_in   = acc_cont;
               vleft_in = vleft_ff - 3'd1;
            end
         end
         OP_PAY: begin
            rem_in = rem_dec;
            lbl_in = lbl_dec;
            if (lend_now) begin
               cur_in = cur_ff + LACE_W'(1);
               if (mode_ff == MODE_FIXED) begin
                  lbl_in = run_ff[LB-1:0];
               end
            end
         end
         OP_SWAL: begin
            rem_in = rem_dec;
         end
         OP_DIV_STEP: begin
            cnt_in = cnt_ff - CW'(1);
            if (trial_ok) begin
               r_in = trial[8:0];
               q_in = {q_ff[LB-2:0], 1'b1};
            end else begin
               r_in = shifted[8:0];
               q_in = {q_ff[LB-2:0], 1'b0};
            end
         end
         OP_DIV_DONE: begin
            run_in = 64'(q_ff);
            cur_in = '0;
            lbl_in = q_ff;
         end
         OP_VDONE: begin
            delta_in = dval;
            dneg_in  = !dpos;
            if (cur_ff == '0) begin
               run_in    = {8'b0, acc_ff};
               ram_we    = (total_ff > LACE_W'(1));
               ram_waddr = '0;
               ram_wdata = acc_ff[LB-1:0];
            end
         end
         OP_VAPPLY: begin
            run_in    = run_apply;
            ram_we    = 1'b1;
            ram_wdata = run_apply[LB-1:0];
         end
         OP_USED: begin
            if (used_over) begin
               over_in = 1'b1;
            end else begin
               used_in = used_sum[31:0];
            end
            cur_in = cur_ff + LACE_W'(1);
            if (mode_ff == MODE_XIPH) begin
               run_in = '0;
            end
         end
         OP_FIN: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(total_ff - LACE_W'(1));
            ram_wdata = fin_size;
            cur_in    = '0;
         end
         OP_SK_CHK: begin
            if (rd_data != '0) begin
               lbl_in = rd_data;
            end else begin
               cur_in = cur_ff + LACE_W'(1);
               lbl_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      valid_in = valid_ff;
      obyte_in = obyte_ff;
      oidx_in  = oidx_ff;
      olend_in = olend_ff;
      obend_in = obend_ff;
      oerr_in  = oerr_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.fault) begin
         valid_in = 1'b1;
         obyte_in = '0;
         oidx_in  = '0;
         olend_in = 1'b0;
         obend_in = 1'b0;
         oerr_in  = cmd.code;
      end else if (cmd.emit) begin
         valid_in = 1'b1;
         obyte_in = in_byte;
         oerr_in  = ERR_OK;
         if (cmd.op == OP_START) begin
            oidx_in  = '0;
            olend_in = first_last;
            obend_in = first_last;
         end else begin
            oidx_in  = cur_ff[7:0];
            olend_in = lend_now;
            obend_in = last_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         mode_ff  <= MODE_NONE;
         total_ff <= LACE_W'(1);
         cur_ff   <= '0;
         run_ff   <= '0;
         vlen_ff  <= '0;
         vleft_ff <= '0;
         used_ff  <= '0;
         over_ff  <= 1'b0;
         lbl_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         mode_ff  <= mode_in;
         total_ff <= total_in;
         cur_ff   <= cur_in;
         run_ff   <= run_in;
         vlen_ff  <= vlen_in;
         vleft_ff <= vleft_in;
         used_ff  <= used_in;
         over_ff  <= over_in;
         lbl_ff   <= lbl_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      delta_ff <= delta_in;
      dneg_ff  <= dneg_in;
      obyte_ff <= obyte_in;
      oidx_ff  <= oidx_in;
      olend_ff <= olend_in;
      obend_ff <= obend_in;
      oerr_ff  <= oerr_in;
   end

   assign rsp_tvalid = valid_ff;
   assign out_byte   = obyte_ff;
   assign lace_index = oidx_ff;
   assign lace_end   = olend_ff;
   assign block_end  = obend_ff;
   assign error_code = oerr_ff;

`ifndef SYNTH
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && oerr_ff != ERR_OK) |-> (obyte_ff == '0 && !olend_ff && !obend_ff))
      else $error("error result carries payload");
   a_used_fit: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FIN) |-> ({1'b0, used_ff} <= 33'(rem_ff)))
      else $error("lace sizes exceed block at finish");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_STEP) |=> (r_ff < 9'(total_ff)))
      else $error("divider remainder out of range");
`endif

endmodule

// ===== rtl/core/lsp_ctrl.sv =====
// Controller state machine of the lace splitter: sequences header decode and payload.
module lsp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  lsp_pkg::stat_type stat,
   output lsp_pkg::cmd_type  cmd
);
   import lsp_pkg::*;

   state_type state_ff, state_in;
   logic      go;
   logic      accept;

   assign go     = stat.out_free;
   assign accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (stat.req_mode == MODE_NONE) begin
                  state_in = stat.first_last ? ST_IDLE : ST_PAY;
               end else if (stat.count_over) begin
                  state_in = stat.first_last ? ST_IDLE : ST_SWAL;
               end else if (stat.req_mode == MODE_XIPH) begin
                  if (stat.b_zero) state_in = ST_FIN;
                  else if (stat.first_last) state_in = ST_IDLE;
                  else state_in = ST_XIPH;
               end else if (stat.req_mode == MODE_FIXED) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = stat.first_last ? ST_IDLE : ST_EBML;
               end
            end
         end
         ST_XIPH: begin
            if (accept) begin
               if (!stat.b_full) state_in = ST_USED;
               else if (stat.last_now) state_in = ST_IDLE;
            end
         end
         ST_EBML: begin
            if (accept) begin
               if (stat.vint_bad) state_in = stat.last_now ? ST_IDLE : ST_SWAL;
               else if (stat.vint_done_now) state_in = ST_VDONE;
            end
         end
         ST_PAY: begin
            if (accept) begin
               if (stat.last_now) state_in = ST_IDLE;
               else if (stat.lend_now && stat.mode != MODE_FIXED) state_in = ST_SKRD;
            end
         end
         ST_SWAL: begin
            if (accept && stat.last_now) state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (go && stat.div_last) state_in = ST_DIVCHK;
         end
         ST_DIVCHK: begin
            if (go) begin
               if (stat.div_rem_nz) state_in = stat.rem_zero ? ST_IDLE : ST_SWAL;
               else state_in = stat.rem_zero ? ST_IDLE : ST_PAY;
            end
         end
         ST_VDONE: begin
            if (go) begin
               if (stat.allones) state_in = stat.rem_zero ? ST_IDLE : ST_SWAL;
               else if (!stat.cur_zero) state_in = ST_VAPPLY;
               else if (stat.total_gt1) state_in = ST_USED;
               else state_in = ST_FIN;
            end
         end
         ST_VAPPLY: begin
            if (go) begin
               if (stat.neg_fault) state_in = stat.rem_zero ? ST_IDLE : ST_SWAL;
               else state_in = ST_USED;
            end
         end
         ST_USED: begin
            if (go) begin
               if (stat.at_needed) state_in = ST_FIN;
               else if (stat.rem_zero) state_in = ST_IDLE;
               else if (stat.mode == MODE_XIPH) state_in = ST_XIPH;
               else state_in = ST_EBML;
            end
         end
         ST_FIN: begin
            if (go) begin
               if (stat.fin_fault) state_in = stat.rem_zero ? ST_IDLE : ST_SWAL;
               else state_in = stat.rem_zero ? ST_IDLE : ST_SKRD;
            end
         end
         ST_SKRD: begin
            if (go) state_in = ST_SKCHK;
         end
         ST_SKCHK: begin
            if (go) begin
               if (stat.rd_nonzero || stat.skip_end) state_in = ST_PAY;
               else state_in = ST_SKRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op     = OP_NONE;
      cmd.emit   = 1'b0;
      cmd.fault  = 1'b0;
      cmd.code   = ERR_OK;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = go;
            if (accept) begin
               cmd.op = OP_START;
               if (stat.req_mode == MODE_NONE) begin
                  cmd.emit = 1'b1;
               end else if (stat.count_over) begin
                  cmd.fault = 1'b1;
                  cmd.code  = ERR_SIZE;
               end else if (stat.req_mode == MODE_XIPH) begin
                  if (!stat.b_zero && stat.first_last) begin
                     cmd.fault = 1'b1;
                     cmd.code  = ERR_XIPH;
                  end
               end else if (stat.req_mode == MODE_EBML && stat.first_last) begin
                  cmd.fault = 1'b1;
                  cmd.code  = ERR_VINT;
               end
            end
         end
         ST_XIPH: begin
            req_tready = go;
            if (accept) begin
               cmd.op = OP_XIPH;
               if (stat.b_full && stat.last_now) begin
                  cmd.fault = 1'b1;
                  cmd.code  = ERR_XIPH;
               end
            end
         end
         ST_EBML: begin
            req_tready = go;
            if (accept) begin
               cmd.op = OP_EBML;
               if (stat.vint_bad) begin
                  cmd.fault = 1'b1;
                  cmd.code  = ERR_VINT;
               end
            end
         end
         ST_PAY: begin
            req_tready = go;
            if (accept) begin
               cmd.op   = OP_PAY;
               cmd.emit = 1'b1;
            end
         end
         ST_SWAL: begin
            req_tready = go;
            if (accept) cmd.op = OP_SWAL;
         end
         ST_DIV: begin
            if (go) cmd.op = OP_DIV_STEP;
         end
         ST_DIVCHK: begin
            if (go) begin
               if (stat.div_rem_nz) begin
                  cmd.fault = 1'b1;
                  cmd.code  = ERR_FIXED;
               end else begin
                  cmd.op = OP_DIV_DONE;
               end
            end
         end
         ST_VDONE: begin
            if (go) begin
               if (stat.allones) begin
                  cmd.fault = 1'b1;
                  cmd.code  = ERR_VINT;
               end else begin
                  cmd.op = OP_VDONE;
               end
            end
         end
         ST_VAPPLY: begin
            if (go) begin
               if (stat.neg_fault) begin
                  cmd.fault = 1'b1;
                  cmd.code  = ERR_NEG;
               end else begin
                  cmd.op = OP_VAPPLY;
               end
            end
         end
         ST_USED: begin
            if (go) begin
               cmd.op = OP_USED;
               // header ran into the block end before all sizes were read
               if (!stat.at_needed && stat.rem_zero) begin
                  cmd.fault = 1'b1;
                  cmd.code  = (stat.mode == MODE_XIPH) ? ERR_XIPH : ERR_VINT;
               end
            end
         end
         ST_FIN: begin
            if (go) begin
               if (stat.fin_fault) begin
                  cmd.fault = 1'b1;
                  cmd.code  = ERR_SIZE;
               end else begin
                  cmd.op = OP_FIN;
               end
            end
         end
         ST_SKRD: begin
         end
         ST_SKCHK: begin
            if (go) cmd.op = OP_SK_CHK;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_skchk_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKCHK) |-> ($past(state_ff) == ST_SKRD))
      else $error("size check without a RAM read cycle");
   a_divchk_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVCHK) |-> ($past(state_ff) == ST_DIV))
      else $error("remainder check without division");
   a_fault_exit: assert property (@(posedge clock) disable iff (reset)
      cmd.fault |=> (state_ff == ST_IDLE || state_ff == ST_SWAL))
      else $error("header fault did not end the block");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> stat.out_free)
      else $error("request taken while result register is blocked");
`endif

endmodule

// ===== bench/lace_checker.sv =====
// Lace splitter checker: watches both channels, predicts responses and compares.
`timescale 1ns / 1ps
module lace_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic [3:0]  rsp_tuser,
   output int          fail_count,
   output int          pending
);
   import lsp_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] lace;
      logic       lend;
      logic       bend;
      err_type    code;
   } lace_rsp_type;

   typedef enum int {PH_IDLE, PH_XIPH, PH_EBML, PH_PAY, PH_SWAL} parse_phase_type;

   localparam longint LMASK = 64'hFF_FFFF;
   localparam longint U32MAX = 64'hFFFF_FFFF;

   lace_rsp_type    expected_q[$];
   parse_phase_type ph;
   longint          seen, blen, run_sz, accum, used, lbl;
   int              lmode, ltotal, cur, vlen, vleft;
   bit              over;
   longint          sizes[256];

   function automatic longint lsize(int i);
      if (lmode == MODE_FIXED) return run_sz;
      return (i < 256) ? sizes[i] : 0;
   endfunction

   task automatic skip_empty();
      while (cur < ltotal && lsize(cur) == 0) cur++;
      lbl = (cur < ltotal) ? lsize(cur) : 0;
   endtask

   task automatic store(int i, longint v);
      if (i < 256) sizes[i] = v & LMASK;
   endtask

   task automatic add_used(longint v);
      if (v > U32MAX || used + v > U32MAX) over = 1;
      else used += v;
   endtask

   task automatic push_fault(err_type c);
      lace_rsp_type r;
      r = '0;
      r.code = c;
      expected_q = {expected_q, r};
      ph = (seen >= blen) ? PH_IDLE : PH_SWAL;
   endtask

   task automatic enter_payload();
      cur = 0;
      if (blen - seen == 0) ph = PH_IDLE;
      else begin
         ph = PH_PAY;
         skip_empty();
      end
   endtask

   task automatic finish_header();
      longint rem;
      rem = blen - seen;
      if (over || used > rem) push_fault(ERR_SIZE);
      else begin
         store(ltotal - 1, rem - used);
         enter_payload();
      end
   endtask

   task automatic vint_finish(bit last);
      longint bias;
      int     need;
      int     sh;
      sh = 7 * vlen;
      need = (ltotal > 1) ? ltotal - 1 : 1;
      if (accum == ((64'd1 << sh) - 1)) begin
         push_fault(ERR_VINT);
         return;
      end
      if (cur == 0) begin
         run_sz = accum;
         if (ltotal > 1) begin
            store(0, accum);
            add_used(accum);
         end
      end else begin
         bias = (64'd1 << (sh - 1)) - 1;
         if (accum >= bias) run_sz += accum - bias;
         else if (bias - accum > run_sz) begin
            push_fault(ERR_NEG);
            return;
         end else run_sz -= bias - accum;
         store(cur, run_sz);
         add_used(run_sz);
      end
      cur++;
      if (cur >= need) finish_header();
      else if (last) push_fault(ERR_VINT);
   endtask

   task automatic predict_byte(logic [39:0] d);
      int           b;
      bit           last;
      lace_rsp_type r;
      int           mask;
      int           len;
      longint       rem;
      b = d[7:0];
      if (ph == PH_IDLE) begin
         blen = d[33:10];
         if (blen == 0) blen = 1;
         lmode = d[9:8];
         seen = 1; used = 0; over = 0; run_sz = 0;
         vlen = 0; vleft = 0; accum = 0; cur = 0; ltotal = 1;
         last = seen >= blen;
         if (lmode == MODE_NONE) begin
            store(0, blen);
            ph = PH_PAY;
            lbl = blen;
         end else begin
            ltotal = b + 1;
            if (lmode == MODE_XIPH) begin
               if (ltotal == 1) finish_header();
               else if (last) push_fault(ERR_XIPH);
               else ph = PH_XIPH;
            end else if (lmode == MODE_FIXED) begin
               rem = blen - seen;
               if (rem % ltotal != 0) push_fault(ERR_FIXED);
               else begin
                  run_sz = rem / ltotal;
                  enter_payload();
               end
            end else if (last) push_fault(ERR_VINT);
            else ph = PH_EBML;
            return;
         end
      end else begin
         seen++;
         last = seen >= blen;
      end
      case (ph)
         PH_XIPH: begin
            run_sz += b;
            if (b != 255) begin
               store(cur, run_sz);
               add_used(run_sz);
               run_sz = 0;
               cur++;
               if (cur >= ltotal - 1) begin
                  finish_header();
                  return;
               end
            end
            if (last) push_fault(ERR_XIPH);
         end
         PH_EBML: begin
            if (vleft == 0) begin
               if (b == 0) begin
                  push_fault(ERR_VINT);
                  return;
               end
               mask = 'h80; len = 1;
               while ((b & mask) == 0) begin
                  mask >>= 1;
                  len++;
               end
               if (len > blen - seen + 1) begin
                  push_fault(ERR_VINT);
                  return;
               end
               accum = b & (mask - 1);
               vlen = len;
               vleft = len - 1;
            end else begin
               accum = (accum << 8) | b;
               vleft--;
            end
            if (vleft == 0) vint_finish(last);
         end
         PH_PAY: begin
            if (lbl > 0) lbl--;
            r.data = d[7:0];
            r.lace = cur[7:0];
            r.lend = (lbl == 0);
            r.bend = last;
            r.code = ERR_OK;
            expected_q = {expected_q, r};
            if (r.lend) begin
               cur++;
               skip_empty();
            end
            if (last) ph = PH_IDLE;
         end
         default: if (last) ph = PH_IDLE;
      endcase
   endtask

   always @(posedge clock) begin
      lace_rsp_type got, exp_r;
      if (reset) begin
         ph = PH_IDLE;
         fail_count <= 0;
         expected_q.delete();
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast, rsp_tuser[0],
                   err_type'(rsp_tuser[3:1])};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response act=%h", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q[0];
               expected_q.delete(0);
               if (got !== exp_r) begin
                  $display("%0t: mismatch exp byte=%h lace=%0d lend=%b bend=%b err=%0d",
                           $realtime, exp_r.data, exp_r.lace, exp_r.lend, exp_r.bend,
                           exp_r.code);
                  $display("%0t:          act byte=%h lace=%0d lend=%b bend=%b err=%0d",
                           $realtime, got.data, got.lace, got.lend, got.bend, got.code);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) predict_byte(req_tdata);
         pending <= expected_q.size();
      end
   end
endmodule

// ===== bench/tb_top.sv =====
// Lace splitter testbench top: block stimulus, random idling and verdict.
`timescale 1ns / 1ps
module tb_top;
   import lsp_pkg::*;

   logic        clock, reset;
   logic        req_tvalid, req_tready, rsp_tvalid, rsp_tready, rsp_tlast;
   logic [39:0] req_tdata;
   logic [15:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   int          fail_count, pending, cycles;
   bit          hold_rsp;
   logic [7:0]  body[$];

   matroska_lace_splitter dut (.*);

   lace_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // receiver: random stalls, plus a long hold-off when requested
   initial begin
      rsp_tready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         rsp_tready <= ($urandom_range(0, 3) != 0) || gap_len() == 0;
         @(posedge clock);
      end
   end

   task automatic send_block(logic [1:0] mode, logic [23:0] len);
      logic [39:0] d;
      int          g;
      for (int i = 0; i < body.size(); i++) begin
         d = '0;
         d[7:0] = body[i];
         d[9:8] = (i == 0) ? mode : 2'($urandom);
         d[33:10] = (i == 0) ? len : 24'($urandom);
         req_tvalid <= 1;
         req_tdata <= d;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         g = gap_len();
         if (g > 0) begin
            req_tvalid <= 0;
            repeat (g) @(posedge clock);
         end
      end
   endtask

   // build a body for a given lacing and send it; broken corrupts the body or its length
   task automatic make_block(logic [1:0] mode, int nlace, bit broken);
      int sz, n, v, len;
      body.delete();
      if (mode == MODE_NONE) begin
         n = $urandom_range(1, 12);
         repeat (n) body = {body, 8'($urandom)};
      end else begin
         body = {body, 8'(nlace - 1)};
         if (mode == MODE_XIPH) begin
            repeat (nlace - 1) begin
               sz = $urandom_range(0, 5) == 0 ? $urandom_range(255, 300)
                                              : $urandom_range(0, 4);
               while (sz >= 255) begin
                  body = {body, 8'hFF};
                  sz -= 255;
               end
               body = {body, 8'(sz)};
            end
            n = $urandom_range(0, 5);
         end else if (mode == MODE_FIXED) begin
            n = nlace * $urandom_range(0, 3);
         end else begin
            v = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) begin
               body = {body, 8'(8'h40 | (v >> 8))};
               body = {body, 8'(v)};
            end else body = {body, 8'(8'h80 | v)};
            repeat (nlace > 1 ? nlace - 2 : 0) begin
               v = 63 + $urandom_range(0, 4) - 2;
               if ($urandom_range(0, 4) == 0) begin
                  v = 8191 + $urandom_range(0, 4) - 2;
                  body = {body, 8'(8'h40 | (v >> 8))};
                  body = {body, 8'(v)};
               end else body = {body, 8'(8'h80 | v)};
            end
            n = $urandom_range(0, 6);
         end
         repeat (n) body = {body, 8'($urandom)};
      end
      if (broken) begin
         v = $urandom_range(0, 2);
         if (v == 0 && body.size() > 1) body[$urandom_range(0, body.size() - 1)] = $urandom;
         else if (v == 1 && body.size() > 1) body.pop_back();
         else body = {body, 8'($urandom)};
      end
      len = body.size();
      // random length mismatch occasionally to exercise truncation
      if (broken && $urandom_range(0, 1)) len = $urandom_range(1, body.size());
      while (body.size() > len) body.pop_back();
      send_block(mode, len[23:0]);
   endtask

   task automatic raw_block(logic [1:0] mode, logic [23:0] len, logic [7:0] b0,
                            logic [7:0] b1);
      body.delete();
      body = {body, b0};
      for (int i = 1; i < len; i++) body = {body, (i == 1) ? b1 : 8'($urandom)};
      send_block(mode, len);
   endtask

   initial begin
      int sent;
      cycles = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      hold_rsp = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed cases
      raw_block(MODE_NONE, 1, 8'hFF, 0);              // single-byte block
      raw_block(MODE_NONE, 0, 8'h00, 0);              // zero length taken as one
      raw_block(MODE_XIPH, 1, 8'h03, 0);              // header cut short
      raw_block(MODE_XIPH, 3, 8'h00, 8'hAA);          // one Xiph lace
      raw_block(MODE_FIXED, 4, 8'h01, 8'h55);         // not divisible
      raw_block(MODE_FIXED, 5, 8'h03, 8'h55);         // four laces of one
      raw_block(MODE_FIXED, 1, 8'hFF, 0);             // all laces empty
      raw_block(MODE_EBML, 3, 8'h00, 8'h00);          // zero vint byte
      raw_block(MODE_EBML, 3, 8'h00, 8'hFF);          // all-ones vint
      raw_block(MODE_EBML, 4, 8'h00, 8'h81);          // one lace, size ignored
      raw_block(MODE_EBML, 3, 8'h01, 8'h01);          // vint longer than block
      raw_block(MODE_XIPH, 4, 8'h01, 8'h09);          // sizes exceed block
      raw_block(MODE_EBML, 6, 8'h02, 8'h81);
      raw_block(MODE_EBML, 5, 8'h02, 8'h82);
      hold_rsp = 1;                                   // long receiver hold-off
      raw_block(MODE_NONE, 40, 8'h5A, 8'hC3);
      sent = 0;
      while (sent < 1300) begin
         make_block(2'($urandom), $urandom_range(0, 9) == 0 ? $urandom_range(1, 256)
                                                           : $urandom_range(1, 6),
                    $urandom_range(0, 5) == 0);
         sent += body.size();
      end
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/lsp_pkg.sv
rtl/core/lsp_ram.sv
rtl/core/lsp_dp.sv
rtl/core/lsp_ctrl.sv
rtl/core/matroska_lace_splitter.sv
bench/lace_checker.sv
bench/tb_top.sv
